### hdl/fdrl_pkg.sv
`timescale 1ns / 1ps

package fdrl_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int ID_W      = 32;
   localparam int CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_DUMP = 1'b1
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [ID_W-1:0]   ident;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   ident_out;
      logic [CAP_W-1:0]  held_count;
      logic              is_empty;
      logic              last;
   } rsp_type;

endpackage

### hdl/fdrl_store.sv
`timescale 1ns / 1ps

module fdrl_store
   import fdrl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [ID_W-1:0] wr_data,
   input  logic            rd_en,
   input  logic [AW-1:0]   rd_addr,
   output logic [ID_W-1:0] rd_data
);

   logic [ID_W-1:0] mem [DEPTH];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fdrl_ctrl.sv
`timescale 1ns / 1ps

module fdrl_ctrl
   import fdrl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int FW    = $clog2(DEPTH + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  req_type         req,
   input  logic [FW-1:0]   cap,
   output logic            busy,
   output logic            rsp_strobe,
   output rsp_type         rsp,
   output logic            mem_wr_en,
   output logic [AW-1:0]   mem_wr_addr,
   output logic [ID_W-1:0] mem_wr_data,
   output logic            mem_rd_en,
   output logic [AW-1:0]   mem_rd_addr,
   input  logic [ID_W-1:0] mem_rd_data
);

   typedef enum logic [1:0] {
      IDLE,
      SEARCH,
      INSERT,
      DUMP
   } state_type;

   state_type       state_ff, state_in;
   logic            busy_ff, busy_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [AW-1:0]   oldest_ff, oldest_in;
   logic [AW-1:0]   scan_ff, scan_in;
   logic [FW-1:0]   cnt_ff, cnt_in;
   logic [ID_W-1:0] ident_ff, ident_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_ff, rsp_in;
   logic            at_end;

   // circular index: base + off, both below 2*DEPTH in sum
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [FW-1:0] off);
      logic [FW:0] sum;
      sum = {{(FW + 1 - AW){1'b0}}, base} + {1'b0, off};
      if (sum >= (FW + 1)'(DEPTH)) begin
         sum = sum - (FW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign at_end = (cnt_ff == fill_ff - FW'(1));

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      scan_in       = scan_ff;
      cnt_in        = cnt_ff;
      ident_in      = ident_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wrap_add(oldest_ff, fill_ff);
      mem_wr_data   = ident_ff;

      case (state_ff)
         IDLE: begin
            if (start) begin
               ident_in = req.ident;
               cnt_in   = '0;
               if (req.func == FUNC_PUSH) begin
                  busy_in = 1'b1;
                  if (fill_ff == '0) begin
                     state_in = INSERT;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = oldest_ff;
                     scan_in     = oldest_ff;
                     state_in    = SEARCH;
                  end
               end else if (fill_ff == '0) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.ident_out  = '0;
                  rsp_in.held_count = '0;
                  rsp_in.is_empty   = 1'b1;
                  rsp_in.last       = 1'b1;
               end else begin
                  // start from the newest entry
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = wrap_add(oldest_ff, fill_ff - FW'(1));
                  scan_in     = mem_rd_addr;
                  busy_in     = 1'b1;
                  state_in    = DUMP;
               end
            end
         end
         SEARCH: begin
            if (mem_rd_data == ident_ff) begin
               // already held: drop the push, keep the age
               state_in = IDLE;
               busy_in  = 1'b0;
            end else if (at_end) begin
               state_in = INSERT;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = wrap_add(scan_ff, FW'(1));
               scan_in     = mem_rd_addr;
               cnt_in      = cnt_ff + FW'(1);
            end
         end
         INSERT: begin
            mem_wr_en = 1'b1;
            if (fill_ff >= cap) begin
               // evict down to capacity - 1, then store the new word
               oldest_in = wrap_add(oldest_ff, fill_ff - cap + FW'(1));
               fill_in   = cap;
            end else begin
               fill_in   = fill_ff + FW'(1);
            end
            state_in = IDLE;
            busy_in  = 1'b0;
         end
         DUMP: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.ident_out  = mem_rd_data;
            rsp_in.held_count = CAP_W'(fill_ff);
            rsp_in.is_empty   = 1'b0;
            rsp_in.last       = at_end;
            if (at_end) begin
               state_in = IDLE;
               busy_in  = 1'b0;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = (scan_ff == '0) ? AW'(DEPTH - 1) : scan_ff - AW'(1);
               scan_in     = mem_rd_addr;
               cnt_in      = cnt_ff + FW'(1);
            end
         end
         default: begin
            state_in = IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         busy_ff       <= 1'b0;
         fill_ff       <= '0;
         oldest_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         fill_ff       <= fill_in;
         oldest_ff     <= oldest_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      scan_ff  <= scan_in;
      cnt_ff   <= cnt_in;
      ident_ff <= ident_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

`ifndef ASSERT_OFF
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !mem_rd_en)
      else $error("entry memory read and written in one cycle");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FW'(DEPTH)) && (oldest_ff <= AW'(DEPTH - 1)))
      else $error("fill or oldest pointer out of range");

   a_dump_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.last |=>
         rsp_strobe_ff && (rsp_ff.held_count == $past(rsp_ff.held_count)))
      else $error("dump burst broken or count changed");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.is_empty |-> rsp_ff.last && (rsp_ff.held_count == '0))
      else $error("empty word not a lone final word");

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != IDLE))
      else $error("busy disagrees with sequencer state");
`endif

endmodule

### hdl/fifo_distinct_recent_list.sv
`timescale 1ns / 1ps

// Keeps up to capacity distinct 32-bit identifiers in arrival order.
// Request: raise start with req_data; the word is taken on an edge where
// busy is low. func PUSH adds ident unless it is already held (no refresh);
// a new ident evicts the oldest entry when the list is full. func DUMP
// returns every held ident, newest first, one word per cycle on rsp_data,
// each marked by rsp_strobe for one cycle; the final word carries last.
// A dump of an empty list returns one word with is_empty and last set.
// Timing: a push compares one stored entry per cycle through the single
// read port of the entry memory, oldest first, and stops at a match; a
// new ident is written once every held entry has been compared. A dump's
// first word passes through the registered memory read and then the
// response register. An empty dump answers in the cycle after acceptance.
// csr_wr_en/csr_wr_data write capacity (0 acts as 1, above DEPTH clamps);
// write it only while busy is low and no dump words are pending.
// Reset empties the list and sets capacity to 16; no clearing pass.
// The receiver cannot stall; rsp_data is valid only while rsp_strobe is high.
module fifo_distinct_recent_list
   import fdrl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [FW-1:0]    eff_cap;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr;
   logic [ID_W-1:0]  mem_wr_data;
   logic             mem_rd_en;
   logic [AW-1:0]    mem_rd_addr;
   logic [ID_W-1:0]  mem_rd_data;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // clamp capacity into 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = FW'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         eff_cap = FW'(DEPTH);
      end else begin
         eff_cap = FW'(cap_ff);
      end
   end

   fdrl_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .FW    (FW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_data),
      .cap         (eff_cap),
      .busy        (busy),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   fdrl_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
